### rtl/pic_pkg.sv
// shared types, constants and microcode rom of the clamped pi controller
package pic_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned GainW   = 16;
    localparam int unsigned AccW    = 32;
    localparam int unsigned ErrW    = SampleW + 1;
    localparam int unsigned UpW     = 26;
    localparam int unsigned MulAW   = GainW + 1;
    localparam int unsigned ProdW   = MulAW + UpW;
    localparam int unsigned SumW    = ProdW + 1;
    localparam int unsigned CtrlW   = UpW + 1;
    localparam int unsigned StepW   = 3;
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KP_GAIN   = 3'd0,
        CFG_KI_GAIN   = 3'd1,
        CFG_OUT_LOW   = 3'd2,
        CFG_OUT_HIGH  = 3'd3,
        CFG_FORM_SEL  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        UOP_ERR       = 3'd0,
        UOP_MUL_KP    = 3'd1,
        UOP_UP        = 3'd2,
        UOP_MUL_KI    = 3'd3,
        UOP_SUM       = 3'd4,
        UOP_CLAMP_ACC = 3'd5,
        UOP_OUT       = 3'd6,
        UOP_PRESET    = 3'd7
    } uop_t;

    typedef struct packed {
        uop_t             op;
        logic             last;
        logic             jmp_preset;
        logic [StepW-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic [GainW-1:0]          kp_gain;
        logic [GainW-1:0]          ki_gain;
        logic signed [SampleW-1:0] out_low_limit;
        logic signed [SampleW-1:0] out_high_limit;
        logic                      form_select;
    } pic_cfg_t;

    typedef struct packed {
        logic active;
        uop_t op;
    } pic_ctl_t;

    localparam logic [StepW-1:0] StepPreset = 3'd7;

    function automatic ucode_t ucode_rom(input logic [StepW-1:0] addr);
        ucode_t w;
        w = '{op: UOP_ERR, last: 1'b0, jmp_preset: 1'b0, target: '0};
        unique case (addr)
            3'd0: w = '{op: UOP_ERR,       last: 1'b0, jmp_preset: 1'b1, target: StepPreset};
            3'd1: w = '{op: UOP_MUL_KP,    last: 1'b0, jmp_preset: 1'b0, target: '0};
            3'd2: w = '{op: UOP_UP,        last: 1'b0, jmp_preset: 1'b0, target: '0};
            3'd3: w = '{op: UOP_MUL_KI,    last: 1'b0, jmp_preset: 1'b0, target: '0};
            3'd4: w = '{op: UOP_SUM,       last: 1'b0, jmp_preset: 1'b0, target: '0};
            3'd5: w = '{op: UOP_CLAMP_ACC, last: 1'b0, jmp_preset: 1'b0, target: '0};
            3'd6: w = '{op: UOP_OUT,       last: 1'b1, jmp_preset: 1'b0, target: '0};
            3'd7: w = '{op: UOP_PRESET,    last: 1'b1, jmp_preset: 1'b0, target: '0};
            default: w = '{op: UOP_ERR, last: 1'b1, jmp_preset: 1'b0, target: '0};
        endcase
        return w;
    endfunction

endpackage

### rtl/pic_if.sv
// valid/ready channel interfaces for request and result items
interface pic_req_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    req_type;
    logic signed [pic_pkg::SampleW-1:0]      reference;
    logic signed [pic_pkg::SampleW-1:0]      feedback;
    logic signed [pic_pkg::SampleW-1:0]      integrator_preset;

    modport source (output valid, req_type, reference, feedback, integrator_preset,
                    input ready);
    modport sink   (input valid, req_type, reference, feedback, integrator_preset,
                    output ready);
endinterface

interface pic_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pic_pkg::SampleW-1:0]      control_out;
    logic signed [pic_pkg::SampleW-1:0]      integrator_value;

    modport source (output valid, control_out, integrator_value, input ready);
    modport sink   (input valid, control_out, integrator_value, output ready);
endinterface

### rtl/pic_seq.sv
// microcode sequencer: step counter, rom fetch and preset jump
module pic_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                start_preset,
    input  logic                out_free,
    output logic                idle,
    output pic_pkg::pic_ctl_t   ctl
);
    import pic_pkg::*;

    logic             busy_reg, busy_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             preset_reg, preset_next;
    ucode_t           word;
    logic             active;

    assign word   = ucode_rom(step_reg);
    // last step waits until the result register is free
    assign active = busy_reg && !(word.last && !out_free);
    assign idle   = !busy_reg;
    assign ctl    = '{active: active, op: word.op};

    always_comb
    begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        preset_next = preset_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            step_next   = '0;
            preset_next = start_preset;
        end
        else if (active)
        begin
            if (word.last)
                busy_next = 1'b0;
            else if (word.jmp_preset && preset_reg)
                step_next = word.target;
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            preset_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            preset_reg <= preset_next;
        end
    end

endmodule

### rtl/pic_dpath.sv
// datapath: shared multiplier, integrator, clamps and result register
module pic_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic signed [pic_pkg::SampleW-1:0] reference,
    input  logic signed [pic_pkg::SampleW-1:0] feedback,
    input  logic signed [pic_pkg::SampleW-1:0] integrator_preset,
    input  pic_pkg::pic_cfg_t                  cfg,
    input  pic_pkg::pic_ctl_t                  ctl,
    input  logic                               res_ready,
    output logic                               out_free,
    output logic                               res_valid,
    output logic signed [pic_pkg::SampleW-1:0] control_out,
    output logic signed [pic_pkg::SampleW-1:0] integrator_value
);
    import pic_pkg::*;

    logic signed [SampleW-1:0] ref_reg, fb_reg, preset_reg;
    logic signed [ErrW-1:0]    err_reg;
    logic signed [ProdW-1:0]   prod_reg;
    logic signed [UpW-1:0]     up_reg;
    logic signed [SumW-1:0]    sum_reg;
    logic signed [AccW-1:0]    acc_reg;
    logic signed [SampleW-1:0] ctrl_out_reg, integ_out_reg;
    logic                      valid_reg;

    logic signed [MulAW-1:0]   mul_a;
    logic signed [UpW-1:0]     mul_b;
    logic signed [ProdW-1:0]   mul_p;
    logic signed [SumW-1:0]    acc_lo, acc_hi, acc_upper, acc_clamped;
    logic signed [CtrlW-1:0]   ctrl_sum, ctrl_lo, ctrl_hi, ctrl_upper, ctrl_clamped;
    logic                      emit;

    // one signed multiplier shared by both gain products
    always_comb
    begin
        if (ctl.op == UOP_MUL_KP)
        begin
            mul_a = $signed({1'b0, cfg.kp_gain});
            mul_b = UpW'(err_reg);
        end
        else
        begin
            mul_a = $signed({1'b0, cfg.ki_gain});
            mul_b = cfg.form_select ? UpW'(err_reg) : up_reg;
        end
    end
    assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

    // integrator clamp at q1.31, upper bound first so the low bound wins
    assign acc_lo      = SumW'($signed({cfg.out_low_limit, 16'h0000}));
    assign acc_hi      = SumW'($signed({cfg.out_high_limit, 16'h0000}));
    assign acc_upper   = (sum_reg > acc_hi) ? acc_hi : sum_reg;
    assign acc_clamped = (acc_upper < acc_lo) ? acc_lo : acc_upper;

    // output clamp at q1.15
    assign ctrl_sum     = CtrlW'(up_reg) + CtrlW'($signed(acc_reg[AccW-1 -: SampleW]));
    assign ctrl_lo      = CtrlW'(cfg.out_low_limit);
    assign ctrl_hi      = CtrlW'(cfg.out_high_limit);
    assign ctrl_upper   = (ctrl_sum > ctrl_hi) ? ctrl_hi : ctrl_sum;
    assign ctrl_clamped = (ctrl_upper < ctrl_lo) ? ctrl_lo : ctrl_upper;

    assign emit     = ctl.active && (ctl.op == UOP_OUT || ctl.op == UOP_PRESET);
    assign out_free = !valid_reg || res_ready;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ref_reg    <= reference;
            fb_reg     <= feedback;
            preset_reg <= integrator_preset;
        end
        if (ctl.active)
        begin
            unique case (ctl.op)
                UOP_ERR:       err_reg  <= ErrW'(ref_reg) - ErrW'(fb_reg);
                UOP_MUL_KP:    prod_reg <= mul_p;
                UOP_UP:        up_reg   <= prod_reg[UpW+7:8];
                UOP_MUL_KI:    prod_reg <= mul_p;
                UOP_SUM:       sum_reg  <= SumW'(acc_reg) + SumW'(prod_reg);
                UOP_CLAMP_ACC: ;
                UOP_OUT:
                begin
                    ctrl_out_reg  <= ctrl_clamped[SampleW-1:0];
                    integ_out_reg <= acc_reg[AccW-1 -: SampleW];
                end
                UOP_PRESET:
                begin
                    ctrl_out_reg  <= '0;
                    integ_out_reg <= preset_reg;
                end
                default: ;
            endcase
        end
    end

    // integrator is state and resets to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.active && ctl.op == UOP_CLAMP_ACC)
                acc_reg <= acc_clamped[AccW-1:0];
            else if (ctl.active && ctl.op == UOP_PRESET)
                acc_reg <= {preset_reg, 16'h0000};
            if (emit)
                valid_reg <= 1'b1;
            else if (res_ready)
                valid_reg <= 1'b0;
        end
    end

    assign res_valid        = valid_reg;
    assign control_out      = ctrl_out_reg;
    assign integrator_value = integ_out_reg;

endmodule

### rtl/pi_controller_clamped.sv
// a run item steps through err, mul_kp, up, mul_ki, sum, clamp_acc and out; a preset item
//   runs err and then jumps to preset; the microcode program steps one control word per cycle
//   through the single shared multiplier, unless held at the last step as below, and a new
//   item is taken only once the program of the previous one has ended
// results wait in an output register; the last step holds while it is full and not being taken
// reset: asynchronous active low; clears the integrator, the sequencer and the gains,
//   and sets the limits to full scale with series form selected
module pi_controller_clamped (
    input  logic                               clk,
    input  logic                               rst_n,
    pic_req_if.sink                            in_item,
    pic_res_if.source                          out_item,
    input  logic                               cfg_we,
    input  logic [pic_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [pic_pkg::SampleW-1:0]        cfg_data
);
    import pic_pkg::*;

    // configuration registers
    pic_cfg_t cfg_reg, cfg_next;

    // handshake between the request channel and the sequencer
    logic     seq_idle;
    logic     accept;
    logic     out_free;
    pic_ctl_t ctl;

    // a new item is taken only while no program is running
    assign in_item.ready = seq_idle;
    assign accept        = in_item.valid && seq_idle;

    // register writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KP_GAIN:  cfg_next.kp_gain        = cfg_data;
                CFG_KI_GAIN:  cfg_next.ki_gain        = cfg_data;
                CFG_OUT_LOW:  cfg_next.out_low_limit  = $signed(cfg_data);
                CFG_OUT_HIGH: cfg_next.out_high_limit = $signed(cfg_data);
                CFG_FORM_SEL: cfg_next.form_select    = cfg_data[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain        <= '0;
            cfg_reg.ki_gain        <= '0;
            cfg_reg.out_low_limit  <= 16'sh8000;
            cfg_reg.out_high_limit <= 16'sh7fff;
            cfg_reg.form_select    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // step counter and microcode rom
    pic_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .start_preset (in_item.req_type),
        .out_free     (out_free),
        .idle         (seq_idle),
        .ctl          (ctl)
    );

    // arithmetic, integrator state and result register
    pic_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (accept),
        .reference         (in_item.reference),
        .feedback          (in_item.feedback),
        .integrator_preset (in_item.integrator_preset),
        .cfg               (cfg_reg),
        .ctl               (ctl),
        .res_ready         (out_item.ready),
        .out_free          (out_free),
        .res_valid         (out_item.valid),
        .control_out       (out_item.control_out),
        .integrator_value  (out_item.integrator_value)
    );

endmodule

### rtl/pic_checker.sv
// port-level checks on the clamped pi controller, bound to the top level
module pic_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [15:0]         out_control,
    input logic [15:0]         out_integ
);

    // a result that is not taken stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_control) && $stable(out_integ))
        else $error("result changed while stalled");

    // one item at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a result never appears in the cycle right after its item is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");

endmodule

bind pi_controller_clamped pic_checker u_pic_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_item.valid),
    .in_ready    (in_item.ready),
    .out_valid   (out_item.valid),
    .out_ready   (out_item.ready),
    .out_control (out_item.control_out),
    .out_integ   (out_item.integrator_value)
);
